### rtl/mer_pkg.sv
// Shared types, widths and helper functions for the midpoint ellipse rasterizer.
`default_nettype none

package mer_pkg;

  localparam int COORD_BITS = 12;
  localparam int RAD_BITS   = COORD_BITS - 1;
  localparam int OUT_W      = COORD_BITS + 2;
  localparam int Y_W        = COORD_BITS + 1;
  localparam int SQ_W       = 2 * RAD_BITS;
  localparam int AB_W       = 3 * RAD_BITS;
  localparam int STEP_W     = 3 * RAD_BITS + 4;
  localparam int DEC_W      = 3 * RAD_BITS + 7;
  localparam int COLOR_W    = 8;
  localparam int SEG_IDX_W  = 2;
  localparam int SEG_CNT_W  = 3;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SQUARE,
    OP_PRODUCT,
    OP_INIT,
    OP_SET1,
    OP_SET2,
    OP_R1Y,
    OP_R1D,
    OP_R1X,
    OP_R1E,
    OP_R2X,
    OP_R2D,
    OP_R2Y,
    OP_R2E
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQUARE,
    S_PRODUCT,
    S_INIT,
    S_SET1,
    S_SET2,
    S_EMIT,
    S_R1Y,
    S_R1D,
    S_R1X,
    S_R1E,
    S_R2X,
    S_R2D,
    S_R2Y,
    S_R2E
  } state_t;

  typedef struct packed {
    dp_op_t               op;
    logic                 load_out;
    logic [SEG_IDX_W-1:0] seg_idx;
    logic                 seg_last;
    logic                 seg_done;
  } cmd_t;

  typedef struct packed {
    logic                 busy;
    logic                 second_region;
    logic                 out_free;
    logic [SEG_CNT_W-1:0] seg_count;
    logic                 done_pred;
  } stat_t;

  // Signed halving that rounds toward zero.
  function automatic logic signed [DEC_W-1:0] half_trunc(input logic signed [DEC_W-1:0] v);
    logic signed [DEC_W-1:0] adj;
    adj = v + signed'(DEC_W'(v[DEC_W-1]));
    return adj >>> 1;
  endfunction

endpackage

`default_nettype wire

### rtl/midpoint_ellipse_rasterizer_unit.sv
// Top level of the midpoint ellipse rasterizer: controller plus datapath.
`default_nettype none

// A start item (req_type 0) loads centre, radii, colour and mode and gives no
// segment; the squaring, the a*a*b product, the walk set-up and the region
// check (SET1, SET2) then run one after another in the datapath. Each step
// item (req_type 1) emits n segments (1 to 4, one per cycle through the output
// register while the output is not stalled) and then updates the walk state
// and decision variable in R1Y, R1D, R1X, R1E, SET1, SET2 in the first region
// or R2X, R2D, R2Y, R2E in the second. A step while no ellipse is active is
// accepted and gives nothing. Items are taken one at a time; in_stall is low
// only while the block waits for the next item. ellipse_done is set on every
// segment of the step that ends the ellipse, last_of_step on its final one.
module midpoint_ellipse_rasterizer_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_req_type,
  input  wire logic [mer_pkg::COORD_BITS-1:0]      in_center_x,
  input  wire logic [mer_pkg::COORD_BITS-1:0]      in_center_y,
  input  wire logic [mer_pkg::RAD_BITS-1:0]        in_radius_a,
  input  wire logic [mer_pkg::RAD_BITS-1:0]        in_radius_b,
  input  wire logic [mer_pkg::COLOR_W-1:0]         in_pen_color,
  input  wire logic                                in_fill_mode,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [mer_pkg::OUT_W-1:0]         out_seg_x0,
  output logic signed [mer_pkg::OUT_W-1:0]         out_seg_y0,
  output logic signed [mer_pkg::OUT_W-1:0]         out_seg_x1,
  output logic signed [mer_pkg::OUT_W-1:0]         out_seg_y1,
  output logic [mer_pkg::COLOR_W-1:0]              out_seg_color,
  output logic                                     out_last_of_step,
  output logic                                     out_ellipse_done
);
  import mer_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mer_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  mer_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_radius_a      (in_radius_a),
    .in_radius_b      (in_radius_b),
    .in_pen_color     (in_pen_color),
    .in_fill_mode     (in_fill_mode),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_seg_x0       (out_seg_x0),
    .out_seg_y0       (out_seg_y0),
    .out_seg_x1       (out_seg_x1),
    .out_seg_y1       (out_seg_y1),
    .out_seg_color    (out_seg_color),
    .out_last_of_step (out_last_of_step),
    .out_ellipse_done (out_ellipse_done)
  );

endmodule

`default_nettype wire

### rtl/mer_ctrl.sv
// Sequencing state machine for the ellipse rasterizer.
`default_nettype none

module mer_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_req_type,
  output logic               in_stall,
  input  wire mer_pkg::stat_t stat,
  output mer_pkg::cmd_t      cmd
);
  import mer_pkg::*;

  state_t               state_r, state_nxt;
  logic [SEG_IDX_W-1:0] seg_idx_r, seg_idx_nxt;
  logic                 is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      seg_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      seg_idx_r <= seg_idx_nxt;
    end
  end

  assign is_last = (SEG_CNT_W'(seg_idx_r) + SEG_CNT_W'(1)) == stat.seg_count;

  always_comb begin
    state_nxt    = state_r;
    seg_idx_nxt  = seg_idx_r;
    in_stall     = 1'b1;
    cmd.op       = OP_NONE;
    cmd.load_out = 1'b0;
    cmd.seg_idx  = seg_idx_r;
    cmd.seg_last = is_last;
    cmd.seg_done = stat.done_pred;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_req_type == REQ_START) begin
            cmd.op    = OP_CAPTURE;
            state_nxt = S_SQUARE;
          end else if (stat.busy) begin
            seg_idx_nxt = '0;
            state_nxt   = S_EMIT;
          end
        end
      end
      S_SQUARE:  begin cmd.op = OP_SQUARE;  state_nxt = S_PRODUCT; end
      S_PRODUCT: begin cmd.op = OP_PRODUCT; state_nxt = S_INIT;    end
      S_INIT:    begin cmd.op = OP_INIT;    state_nxt = S_SET1;    end
      S_SET1:    begin cmd.op = OP_SET1;    state_nxt = S_SET2;    end
      S_SET2:    begin cmd.op = OP_SET2;    state_nxt = S_IDLE;    end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          if (is_last) begin
            state_nxt = stat.second_region ? S_R2X : S_R1Y;
          end else begin
            seg_idx_nxt = seg_idx_r + SEG_IDX_W'(1);
          end
        end
      end
      S_R1Y: begin cmd.op = OP_R1Y; state_nxt = S_R1D;  end
      S_R1D: begin cmd.op = OP_R1D; state_nxt = S_R1X;  end
      S_R1X: begin cmd.op = OP_R1X; state_nxt = S_R1E;  end
      S_R1E: begin cmd.op = OP_R1E; state_nxt = S_SET1; end
      S_R2X: begin cmd.op = OP_R2X; state_nxt = S_R2D;  end
      S_R2D: begin cmd.op = OP_R2D; state_nxt = S_R2Y;  end
      S_R2Y: begin cmd.op = OP_R2Y; state_nxt = S_R2E;  end
      S_R2E: begin cmd.op = OP_R2E; state_nxt = S_IDLE; end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/mer_dp.sv
// Datapath: ellipse state, decision arithmetic, segment mirroring and output register.
`default_nettype none

module mer_dp (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire mer_pkg::cmd_t                          cmd,
  output mer_pkg::stat_t                              stat,
  input  wire logic [mer_pkg::COORD_BITS-1:0]         in_center_x,
  input  wire logic [mer_pkg::COORD_BITS-1:0]         in_center_y,
  input  wire logic [mer_pkg::RAD_BITS-1:0]           in_radius_a,
  input  wire logic [mer_pkg::RAD_BITS-1:0]           in_radius_b,
  input  wire logic [mer_pkg::COLOR_W-1:0]            in_pen_color,
  input  wire logic                                   in_fill_mode,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [mer_pkg::OUT_W-1:0]            out_seg_x0,
  output logic signed [mer_pkg::OUT_W-1:0]            out_seg_y0,
  output logic signed [mer_pkg::OUT_W-1:0]            out_seg_x1,
  output logic signed [mer_pkg::OUT_W-1:0]            out_seg_y1,
  output logic [mer_pkg::COLOR_W-1:0]                 out_seg_color,
  output logic                                        out_last_of_step,
  output logic                                        out_ellipse_done
);
  import mer_pkg::*;

  // Control state.
  logic busy_r, second_region_r, out_valid_r;

  // Per-ellipse parameters.
  logic [COORD_BITS-1:0] centre_x_r, centre_y_r;
  logic [RAD_BITS-1:0]   rad_a_r, rad_b_r;
  logic [COLOR_W-1:0]    color_r;
  logic                  filled_r;
  logic [SQ_W-1:0]       a_sq_r, b_sq_r;
  logic [AB_W-1:0]       a_sq_b_r;
  logic signed [DEC_W-1:0] k_r;

  // Walk state.
  logic [COORD_BITS-1:0]    cur_x_r;
  logic signed [Y_W-1:0]    cur_y_r;
  logic signed [DEC_W-1:0]  dec_r, t_r;
  logic signed [STEP_W-1:0] dx_r, dy_r;
  logic                     flag_r;

  // Derived values.
  logic signed [DEC_W-1:0]  a_sq_d, b_sq_d, dx_d, dy_d, sq_diff, sq_diff3;
  logic signed [STEP_W-1:0] two_a_sq, two_b_sq;
  logic signed [OUT_W-1:0]  xc, yc, xs, ys, px, mx, py, my;
  logic signed [OUT_W-1:0]  sx0, sy0, sx1, sy1;
  logic                     x_nz, y_nz;
  logic [SEG_CNT_W-1:0]     seg_count;

  assign a_sq_d   = signed'(DEC_W'(a_sq_r));
  assign b_sq_d   = signed'(DEC_W'(b_sq_r));
  assign dx_d     = DEC_W'(dx_r);
  assign dy_d     = DEC_W'(dy_r);
  assign sq_diff  = a_sq_d - b_sq_d;
  assign sq_diff3 = sq_diff + (sq_diff <<< 1);
  assign two_a_sq = signed'(STEP_W'({a_sq_r, 1'b0}));
  assign two_b_sq = signed'(STEP_W'({b_sq_r, 1'b0}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r          <= 1'b0;
      second_region_r <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_INIT: begin
          busy_r          <= 1'b1;
          second_region_r <= 1'b0;
        end
        OP_SET2: begin
          if (flag_r) begin
            second_region_r <= 1'b1;
          end
        end
        OP_R2E: begin
          if (cur_y_r[Y_W-1]) begin
            busy_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CAPTURE: begin
        centre_x_r <= in_center_x;
        centre_y_r <= in_center_y;
        rad_a_r    <= in_radius_a;
        rad_b_r    <= in_radius_b;
        color_r    <= in_pen_color;
        filled_r   <= in_fill_mode;
      end
      OP_SQUARE: begin
        a_sq_r <= SQ_W'(rad_a_r) * SQ_W'(rad_a_r);
        b_sq_r <= SQ_W'(rad_b_r) * SQ_W'(rad_b_r);
      end
      OP_PRODUCT: begin
        a_sq_b_r <= AB_W'(a_sq_r) * AB_W'(rad_b_r);
        k_r      <= half_trunc(sq_diff3);
      end
      OP_INIT: begin
        cur_x_r <= '0;
        cur_y_r <= signed'(Y_W'(rad_b_r));
        dec_r   <= b_sq_d - signed'(DEC_W'(a_sq_b_r)) + signed'(DEC_W'(a_sq_r >> 2));
        dx_r    <= '0;
        dy_r    <= signed'(STEP_W'({a_sq_b_r, 1'b0}));
      end
      OP_SET1: begin
        t_r    <= k_r - dx_d - dy_d;
        flag_r <= !second_region_r && !(dx_r < dy_r);
      end
      OP_SET2: begin
        if (flag_r) begin
          dec_r <= dec_r + half_trunc(t_r);
        end
      end
      OP_R1Y: begin
        flag_r <= dec_r > 0;
        if (dec_r > 0) begin
          cur_y_r <= cur_y_r - Y_W'(1);
          dy_r    <= dy_r - two_a_sq;
        end
      end
      OP_R1D: begin
        if (flag_r) begin
          dec_r <= dec_r - dy_d;
        end
      end
      OP_R1X: begin
        cur_x_r <= cur_x_r + COORD_BITS'(1);
        dx_r    <= dx_r + two_b_sq;
      end
      OP_R1E: begin
        dec_r <= dec_r + b_sq_d + dx_d;
      end
      OP_R2X: begin
        flag_r <= dec_r < 0;
        if (dec_r < 0) begin
          cur_x_r <= cur_x_r + COORD_BITS'(1);
          dx_r    <= dx_r + two_b_sq;
        end
      end
      OP_R2D: begin
        if (flag_r) begin
          dec_r <= dec_r + dx_d;
        end
      end
      OP_R2Y: begin
        cur_y_r <= cur_y_r - Y_W'(1);
        dy_r    <= dy_r - two_a_sq;
      end
      OP_R2E: begin
        dec_r <= dec_r + a_sq_d - dy_d;
      end
      default: begin
      end
    endcase
  end

  // Mirror the current point about the centre.
  assign xc   = signed'(OUT_W'(centre_x_r));
  assign yc   = signed'(OUT_W'(centre_y_r));
  assign xs   = signed'(OUT_W'(cur_x_r));
  assign ys   = OUT_W'(cur_y_r);
  assign px   = xc + xs;
  assign mx   = xc - xs;
  assign py   = yc + ys;
  assign my   = yc - ys;
  assign x_nz = cur_x_r != '0;
  assign y_nz = cur_y_r != '0;

  always_comb begin
    sx0 = px;
    sy0 = py;
    sx1 = px;
    sy1 = py;
    seg_count = SEG_CNT_W'(1);
    unique case ({filled_r, x_nz})
      2'b11: begin
        seg_count = y_nz ? SEG_CNT_W'(2) : SEG_CNT_W'(1);
        sx1 = mx;
        if (cmd.seg_idx[0]) begin
          sy0 = my;
          sy1 = my;
        end
      end
      2'b10: begin
        sy1 = my;
      end
      2'b01: begin
        seg_count = y_nz ? SEG_CNT_W'(4) : SEG_CNT_W'(2);
        sx0 = cmd.seg_idx[0] ? mx : px;
        sy0 = cmd.seg_idx[1] ? my : py;
        sx1 = sx0;
        sy1 = sy0;
      end
      default: begin
        seg_count = y_nz ? SEG_CNT_W'(2) : SEG_CNT_W'(1);
        if (cmd.seg_idx[0]) begin
          sy0 = my;
          sy1 = my;
        end
      end
    endcase
  end

  // Output register; a new segment loads when the previous one is taken or absent.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_seg_x0       <= sx0;
      out_seg_y0       <= sy0;
      out_seg_x1       <= sx1;
      out_seg_y1       <= sy1;
      out_seg_color    <= color_r;
      out_last_of_step <= cmd.seg_last;
      out_ellipse_done <= cmd.seg_done;
    end
  end

  assign out_valid = out_valid_r;

  assign stat.busy          = busy_r;
  assign stat.second_region = second_region_r;
  assign stat.out_free      = !out_valid_r || !out_stall;
  assign stat.seg_count     = seg_count;
  assign stat.done_pred     = second_region_r && (cur_y_r[Y_W-1] || !y_nz);

endmodule

`default_nettype wire
